// File: sv/line_keyword_matcher_unit_defines.svh
// assertion macros for the line keyword matcher
// used by line_keyword_matcher_unit, no other dependencies
`ifndef LINE_KEYWORD_MATCHER_UNIT_DEFINES_SVH
`define LINE_KEYWORD_MATCHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LKM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LKM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LKM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/lkm_pkg.sv
// shared types, constants and byte folding for the line keyword matcher
// no dependencies
package lkm_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int LEN_W       = 5;
    localparam int LINE_NUM_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXACT_CASE     = 2'd3;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [KEY_BYTES-1:0][7:0] key;
        logic [LEN_W-1:0]          key_length;
        logic                      exact_case;
    } t_match_cfg;

    function automatic t_byte fold(input t_byte c, input logic exact_case);
        if (!exact_case && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: sv/line_keyword_matcher_unit.sv
// line keyword matcher: a line result is registered into the output register, or into
// the skid entry while that is held; one byte accepted every cycle, the only stall being
// a full skid entry while the output side stalls. synchronous active-low reset
// clears line state, the line counter, result valids and the configuration
// (key length 0, case sensitive). depends on lkm_pkg, lkm_cmp and the defines header
`include "line_keyword_matcher_unit_defines.svh"
module line_keyword_matcher_unit #(
    parameter int MAX_KEY_LEN     = 16,
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lkm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_text_byte,
    input  logic                              i_end_of_text,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lkm_pkg::LINE_NUM_W-1:0]    o_line_number
);
    import lkm_pkg::*;

    localparam int FILL_W = $clog2(MAX_KEY_LEN + 1);

    // configuration
    logic [CFG_DATA_W-1:0] r_kw_low, r_kw_high;
    logic [LEN_W-1:0]      r_key_length;
    logic                  r_exact_case;
    t_match_cfg            w_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_low         <= '0;
            r_kw_high        <= '0;
            r_key_length     <= '0;
            r_exact_case     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KEYWORD_LOW:    r_kw_low         <= i_cfg_data;
                REG_KEYWORD_HIGH:   r_kw_high        <= i_cfg_data;
                REG_KEY_LENGTH:     r_key_length     <= i_cfg_data[LEN_W-1:0];
                REG_EXACT_CASE:     r_exact_case     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_cfg.key            = {r_kw_high, r_kw_low};
    assign w_cfg.key_length     = r_key_length;
    assign w_cfg.exact_case     = r_exact_case;

    // line state
    logic [MAX_KEY_LEN-1:0][7:0] r_window, n_window;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic                        r_line_matched, n_line_matched;
    logic                        r_nul_seen, n_nul_seen;
    logic [LINE_COUNT_BITS-1:0]  r_line_count, n_line_count;

    logic                        w_in_fire, w_out_fire;
    logic                        w_nul_now, w_line_end, w_hit, w_res_valid;
    logic [MAX_KEY_LEN-1:0][7:0] w_shifted;
    logic [FILL_W-1:0]           w_fill_inc;
    logic [LINE_COUNT_BITS-1:0]  w_count_inc;
    logic [LINE_NUM_W-1:0]       w_report;
    logic [LEN_W-1:0]            w_eff_len;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_fire = o_out_valid && !i_out_stall;

    assign w_nul_now  = r_nul_seen || (i_text_byte == CHAR_NUL);
    assign w_line_end = (i_text_byte == CHAR_NEWLINE) || i_end_of_text;
    assign w_fill_inc = (r_fill < FILL_W'(MAX_KEY_LEN)) ? r_fill + FILL_W'(1) : r_fill;
    assign w_count_inc = (&r_line_count) ? r_line_count : r_line_count + LINE_COUNT_BITS'(1);

    always_comb begin
        w_shifted[0] = i_text_byte;
        for (int j = 1; j < MAX_KEY_LEN; j++) begin
            w_shifted[j] = r_window[j-1];
        end
    end

    lkm_cmp #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_cmp (
        .i_cfg     (w_cfg),
        .i_window  (w_shifted),
        .i_fill    (w_fill_inc),
        .o_hit     (w_hit),
        .o_eff_len (w_eff_len)
    );

    generate
        if (LINE_COUNT_BITS > LINE_NUM_W) begin : g_sat
            assign w_report = (|w_count_inc[LINE_COUNT_BITS-1:LINE_NUM_W]) ?
                              '1 : w_count_inc[LINE_NUM_W-1:0];
        end else begin : g_ext
            assign w_report = LINE_NUM_W'(w_count_inc);
        end
    endgenerate

    assign w_res_valid = w_line_end &&
                         (r_line_matched || (w_hit && !w_nul_now) || (w_eff_len == '0));

    always_comb begin
        n_window       = r_window;
        n_fill         = r_fill;
        n_line_matched = r_line_matched;
        n_nul_seen     = r_nul_seen;
        n_line_count   = r_line_count;
        if (w_in_fire) begin
            if (w_line_end) begin
                n_fill         = '0;
                n_line_matched = 1'b0;
                n_nul_seen     = 1'b0;
                n_line_count   = i_end_of_text ? '0 : w_count_inc;
            end else begin
                n_nul_seen = w_nul_now;
                if (!w_nul_now) begin
                    n_window       = w_shifted;
                    n_fill         = w_fill_inc;
                    n_line_matched = r_line_matched || w_hit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_line_matched <= 1'b0;
            r_nul_seen     <= 1'b0;
            r_line_count   <= '0;
        end else begin
            r_fill         <= n_fill;
            r_line_matched <= n_line_matched;
            r_nul_seen     <= n_nul_seen;
            r_line_count   <= n_line_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    // output register with one skid entry
    logic                  r_out_valid, r_skid_valid;
    logic [LINE_NUM_W-1:0] r_out_num, r_skid_num;

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_out_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire && w_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_num <= r_skid_num;
            end
        end else if (w_in_fire && w_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_num <= w_report;
            end else begin
                r_out_num <= w_report;
            end
        end
    end

    `LKM_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with empty output")
    `LKM_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, o_out_valid, o_line_number != '0, "line number zero")
    `LKM_ASSERT_NXT(a_text_restart, i_clk, i_rst_n, w_in_fire && i_end_of_text, r_line_count == '0, "line count not cleared at end of text")
    `LKM_ASSERT_NXT(a_no_midline_result, i_clk, i_rst_n, w_in_fire && !w_line_end && !r_out_valid, !o_out_valid, "result without line end")

endmodule

// File: sv/lkm_cmp.sv
// parallel keyword compare against the window of recent line bytes
// depends on lkm_pkg
module lkm_cmp #(
    parameter int MAX_KEY_LEN = 16,
    localparam int FILL_W = $clog2(MAX_KEY_LEN + 1)
) (
    input  lkm_pkg::t_match_cfg               i_cfg,
    input  logic [MAX_KEY_LEN-1:0][7:0]       i_window,
    input  logic [FILL_W-1:0]                 i_fill,
    output logic                              o_hit,
    output logic [lkm_pkg::LEN_W-1:0]         o_eff_len
);
    import lkm_pkg::*;

    logic [LEN_W-1:0] w_clamped;

    assign w_clamped = (i_cfg.key_length > LEN_W'(MAX_KEY_LEN)) ?
                       LEN_W'(MAX_KEY_LEN) : i_cfg.key_length;

    // keyword ends at its first nul byte
    always_comb begin
        o_eff_len = w_clamped;
        for (int k = MAX_KEY_LEN - 1; k >= 0; k--) begin
            if (LEN_W'(k) < w_clamped && i_cfg.key[k] == CHAR_NUL) begin
                o_eff_len = LEN_W'(k);
            end
        end
    end

    // window position j holds keyword byte eff_len-1-j
    always_comb begin : p_match
        logic             all_eq;
        logic [LEN_W-1:0] idx;
        all_eq = 1'b1;
        for (int j = 0; j < MAX_KEY_LEN; j++) begin
            idx = o_eff_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < o_eff_len &&
                fold(i_cfg.key[idx[KEY_IDX_W-1:0]], i_cfg.exact_case) !=
                fold(i_window[j], i_cfg.exact_case)) begin
                all_eq = 1'b0;
            end
        end
        o_hit = all_eq && (o_eff_len != '0) && (6'(i_fill) >= 6'(o_eff_len));
    end

endmodule
